>>> rtl/incremental_deadlock_detector_defines.svh
`ifndef INCREMENTAL_DEADLOCK_DETECTOR_DEFINES_SVH
`define INCREMENTAL_DEADLOCK_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IDD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IDD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/idd_pkg.sv
package idd_pkg;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_DEADLOCK = 2'd1,
    ST_STOPPED  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    DIR_REQUEST = 1'b0,
    DIR_ASSIGN  = 1'b1
  } dir_e;

  typedef struct packed {
    dir_e       dir;
    logic [4:0] res;
    logic [4:0] proc;
  } edge_t;

  localparam int unsigned ResultCap = 32;
  localparam logic [15:0] EdgesSeenMax = 16'hFFFF;

endpackage

>>> rtl/incremental_deadlock_detector.sv
// Channel   | Signals                                          | Direction
// ----------+--------------------------------------------------+----------
// command   | start_i, busy_o, process_id_i, resource_id_i,    | in
//           | direction_i                                      |
// result    | valid_o, status_o, deadlocked_process_o,         | out
//           | edge_number_o, last_o                            |
//
// A refused transaction (stopped, store full, id out of range) shows its single result in the
// cycle after start and leaves busy_o low. A stored edge keeps busy_o high while the work
// degrees are re-initialised, peel passes remove nodes with no work left and the deadlocked
// processes are listed. Reset clears all control state and the degree valid bits;
// no clearing pass is needed. The receiver cannot stall: each result shows for one
// cycle with valid_o high.
module incremental_deadlock_detector
  import idd_pkg::*;
#(
  parameter int unsigned NUM_PROCESSES = 32,
  parameter int unsigned NUM_RESOURCES = 32,
  parameter int unsigned MAX_EDGES     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  process_id_i,
  input  logic [4:0]  resource_id_i,
  input  logic        direction_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [4:0]  deadlocked_process_o,
  output logic [15:0] edge_number_o,
  output logic        last_o
);

  localparam int unsigned NC = NUM_PROCESSES + NUM_RESOURCES;
  localparam int unsigned NW = $clog2(NC);
  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned DW = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW = $clog2(NUM_PROCESSES);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_INS      = 12'b0000_0000_0010,
    S_INIT_RD  = 12'b0000_0000_0100,
    S_INIT_WR  = 12'b0000_0000_1000,
    S_NODE_RD  = 12'b0000_0001_0000,
    S_NODE_CHK = 12'b0000_0010_0000,
    S_SCAN_RD  = 12'b0000_0100_0000,
    S_SCAN_CHK = 12'b0000_1000_0000,
    S_SCAN_DEC = 12'b0001_0000_0000,
    S_EMIT_RD  = 12'b0010_0000_0000,
    S_EMIT_CHK = 12'b0100_0000_0000,
    S_FIN      = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic [DW-1:0] outdeg;
    logic [DW-1:0] work;
  } deg_t;

  state_e        state_q, state_d;
  logic [NW-1:0] node_q, node_d;
  logic [AW-1:0] k_q, k_d;
  logic [PW-1:0] pn_q, pn_d;
  logic [4:0]    fc_q, fc_d;
  logic          pend_q, pend_d;
  logic [4:0]    pend_id_q, pend_id_d;
  logic          progress_q, progress_d;
  logic [NW-1:0] src_q, src_d;
  logic [AW:0]   count_q, count_d;
  logic          stopped_q, stopped_d;
  logic [15:0]   edges_seen_q, edges_seen_d;
  logic [15:0]   num_q, num_d;
  logic [NC-1:0] removed_q;
  logic          removed_clr, removed_set;

  deg_t          deg_mem [NC];
  logic [NC-1:0] deg_vld_q;
  deg_t          deg_rd_q;
  logic          deg_rd_vld_q;
  logic          deg_re, deg_we;
  logic [NW-1:0] deg_ra, deg_wa;
  deg_t          deg_wd;
  deg_t          deg_cur;

  edge_t         edge_mem [MAX_EDGES];
  edge_t         edge_rd_q;
  edge_t         edge_wd;
  logic          edge_we, edge_re;

  logic [NW-1:0] in_src;
  logic [NW-1:0] e_src, e_dst;
  logic          accept, in_range;
  logic          next_edge, next_node;

  logic          emit_v, emit_last;
  status_e       emit_status;
  logic [4:0]    emit_proc;
  logic [15:0]   emit_num;

  logic          out_v_q, out_last_q;
  status_e       out_status_q;
  logic [4:0]    out_proc_q;
  logic [15:0]   out_num_q;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign in_range = ({2'b00, process_id_i} < 7'(NUM_PROCESSES)) &&
                    ({2'b00, resource_id_i} < 7'(NUM_RESOURCES));
  assign edge_wd  = '{dir: dir_e'(direction_i), res: resource_id_i, proc: process_id_i};

  assign in_src = (direction_i == DIR_ASSIGN) ?
                  NW'(8'(NUM_PROCESSES) + {3'b000, resource_id_i}) :
                  NW'({3'b000, process_id_i});
  assign e_src  = (edge_rd_q.dir == DIR_ASSIGN) ?
                  NW'(8'(NUM_PROCESSES) + {3'b000, edge_rd_q.res}) :
                  NW'({3'b000, edge_rd_q.proc});
  assign e_dst  = (edge_rd_q.dir == DIR_ASSIGN) ?
                  NW'({3'b000, edge_rd_q.proc}) :
                  NW'(8'(NUM_PROCESSES) + {3'b000, edge_rd_q.res});

  assign deg_cur = deg_rd_vld_q ? deg_rd_q : '0;

  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    k_d          = k_q;
    pn_d         = pn_q;
    fc_d         = fc_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    progress_d   = progress_q;
    src_d        = src_q;
    count_d      = count_q;
    stopped_d    = stopped_q;
    edges_seen_d = edges_seen_q;
    num_d        = num_q;
    removed_clr  = 1'b0;
    removed_set  = 1'b0;
    deg_re       = 1'b0;
    deg_ra       = '0;
    deg_we       = 1'b0;
    deg_wa       = '0;
    deg_wd       = '0;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    next_edge    = 1'b0;
    next_node    = 1'b0;
    emit_v       = 1'b0;
    emit_last    = 1'b0;
    emit_status  = ST_NONE;
    emit_proc    = '0;
    emit_num     = num_q;

    unique case (state_q)
      S_IDLE: begin
        emit_num = edges_seen_q;
        if (accept) begin
          num_d = edges_seen_q;
          if (edges_seen_q != EdgesSeenMax) begin
            edges_seen_d = edges_seen_q + 16'd1;
          end
          emit_last = 1'b1;
          if (stopped_q) begin
            emit_v      = 1'b1;
            emit_status = ST_STOPPED;
          end else if (count_q == (AW+1)'(MAX_EDGES)) begin
            emit_v      = 1'b1;
            emit_status = ST_FULL;
          end else if (!in_range) begin
            emit_v      = 1'b1;
            emit_status = ST_NONE;
          end else begin
            edge_we = 1'b1;
            count_d = count_q + 1'b1;
            deg_re  = 1'b1;
            deg_ra  = in_src;
            src_d   = in_src;
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        deg_we  = 1'b1;
        deg_wa  = src_q;
        deg_wd  = '{outdeg: deg_cur.outdeg + 1'b1, work: deg_cur.work};
        node_d  = '0;
        state_d = S_INIT_RD;
      end
      S_INIT_RD: begin
        deg_re  = 1'b1;
        deg_ra  = node_q;
        state_d = S_INIT_WR;
      end
      S_INIT_WR: begin
        deg_we = 1'b1;
        deg_wa = node_q;
        deg_wd = '{outdeg: deg_cur.outdeg, work: deg_cur.outdeg};
        if (node_q == NW'(NC - 1)) begin
          node_d      = '0;
          progress_d  = 1'b0;
          removed_clr = 1'b1;
          state_d     = S_NODE_RD;
        end else begin
          node_d  = node_q + 1'b1;
          state_d = S_INIT_RD;
        end
      end
      S_NODE_RD: begin
        deg_re  = 1'b1;
        deg_ra  = node_q;
        state_d = S_NODE_CHK;
      end
      S_NODE_CHK: begin
        if (!removed_q[node_q] && (deg_cur.work == '0)) begin
          removed_set = 1'b1;
          progress_d  = 1'b1;
          k_d         = '0;
          state_d     = S_SCAN_RD;
        end else begin
          next_node = 1'b1;
        end
      end
      S_SCAN_RD: begin
        edge_re = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (e_dst == node_q) begin
          deg_re  = 1'b1;
          deg_ra  = e_src;
          src_d   = e_src;
          state_d = S_SCAN_DEC;
        end else begin
          next_edge = 1'b1;
        end
      end
      S_SCAN_DEC: begin
        if (deg_cur.work != '0) begin
          deg_we = 1'b1;
          deg_wa = src_q;
          deg_wd = '{outdeg: deg_cur.outdeg, work: deg_cur.work - 1'b1};
        end
        next_edge = 1'b1;
      end
      S_EMIT_RD: begin
        deg_re  = 1'b1;
        deg_ra  = NW'(pn_q);
        state_d = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (deg_cur.work != '0) begin
          if (pend_q) begin
            emit_v      = 1'b1;
            emit_status = ST_DEADLOCK;
            emit_proc   = pend_id_q;
          end
          pend_d    = 1'b1;
          pend_id_d = 5'(pn_q);
          fc_d      = fc_q + 1'b1;
        end
        if ((deg_cur.work != '0 && fc_q == 5'(ResultCap - 1)) ||
            pn_q == PW'(NUM_PROCESSES - 1)) begin
          state_d = S_FIN;
        end else begin
          pn_d    = pn_q + 1'b1;
          state_d = S_EMIT_RD;
        end
      end
      S_FIN: begin
        emit_v    = 1'b1;
        emit_last = 1'b1;
        if (pend_q) begin
          emit_status = ST_DEADLOCK;
          emit_proc   = pend_id_q;
          stopped_d   = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (next_edge) begin
      if ({1'b0, k_q} == count_q - 1'b1) begin
        next_node = 1'b1;
      end else begin
        k_d     = k_q + 1'b1;
        state_d = S_SCAN_RD;
      end
    end

    if (next_node) begin
      if (node_q == NW'(NC - 1)) begin
        if (progress_d) begin
          node_d     = '0;
          progress_d = 1'b0;
          state_d    = S_NODE_RD;
        end else begin
          pn_d    = '0;
          fc_d    = '0;
          pend_d  = 1'b0;
          state_d = S_EMIT_RD;
        end
      end else begin
        node_d  = node_q + 1'b1;
        state_d = S_NODE_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_q       <= '0;
      k_q          <= '0;
      pn_q         <= '0;
      fc_q         <= '0;
      pend_q       <= 1'b0;
      progress_q   <= 1'b0;
      count_q      <= '0;
      stopped_q    <= 1'b0;
      edges_seen_q <= '0;
      removed_q    <= '0;
      deg_vld_q    <= '0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_q       <= node_d;
      k_q          <= k_d;
      pn_q         <= pn_d;
      fc_q         <= fc_d;
      pend_q       <= pend_d;
      progress_q   <= progress_d;
      count_q      <= count_d;
      stopped_q    <= stopped_d;
      edges_seen_q <= edges_seen_d;
      out_v_q      <= emit_v;
      if (removed_clr) begin
        removed_q <= '0;
      end else if (removed_set) begin
        removed_q[node_q] <= 1'b1;
      end
      if (deg_we) begin
        deg_vld_q[deg_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q    <= pend_id_d;
    src_q        <= src_d;
    num_q        <= num_d;
    out_last_q   <= emit_last;
    out_status_q <= emit_status;
    out_proc_q   <= emit_proc;
    out_num_q    <= emit_num;
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (deg_re) begin
      deg_rd_q     <= deg_mem[deg_ra];
      deg_rd_vld_q <= deg_vld_q[deg_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[count_q[AW-1:0]] <= edge_wd;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[k_q];
    end
  end

  assign valid_o              = out_v_q;
  assign status_o             = out_status_q;
  assign deadlocked_process_o = out_proc_q;
  assign edge_number_o        = out_num_q;
  assign last_o               = out_last_q;

endmodule

>>> rtl/idd_checker.sv
`include "incremental_deadlock_detector_defines.svh"

module idd_checker
  import idd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [4:0]  process_id_i,
  input logic [4:0]  resource_id_i,
  input logic        direction_i,
  input logic        valid_o,
  input logic [1:0]  status_o,
  input logic [4:0]  deadlocked_process_o,
  input logic [15:0] edge_number_o,
  input logic        last_o
);

  `IDD_ASSERT_IMP(a_refusal_last, valid_o && (status_o == ST_STOPPED || status_o == ST_FULL), last_o, "Refused transaction result is not marked last.")
  `IDD_ASSERT_IMP(a_nonlast_deadlock, valid_o && !last_o, status_o == ST_DEADLOCK && busy_o, "A non-final result must list a deadlock while busy.")
  `IDD_ASSERT_IMP(a_proc_zero, valid_o && status_o != ST_DEADLOCK, deadlocked_process_o == 5'd0, "Process id must be zero without a deadlock.")
  `IDD_ASSERT_NXT(a_stop_after, valid_o && last_o && status_o == ST_DEADLOCK, !valid_o || status_o == ST_STOPPED, "Result after a deadlock listing is not stopped.")

endmodule

bind incremental_deadlock_detector idd_checker u_idd_checker (.*);
